/* rtl/core/owd_pkg.sv */
// Shared types, constants and classification functions for the outage window detector.
package owd_pkg;

    localparam int TIME_W  = 40;
    localparam int COUNT_W = 12;
    localparam int DUR_W   = 31;
    localparam int RISK_W  = 2;
    localparam int CONF_W  = 4;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 136;

    localparam logic [RISK_W-1:0] RISK_LOW      = 2'd0;
    localparam logic [RISK_W-1:0] RISK_MEDIUM   = 2'd1;
    localparam logic [RISK_W-1:0] RISK_HIGH     = 2'd2;
    localparam logic [RISK_W-1:0] RISK_CRITICAL = 2'd3;

    localparam logic [TIME_W-1:0]  SHORT_LIMIT = 40'd60;
    localparam logic [TIME_W-1:0]  LONG_LIMIT  = 40'd300;
    localparam logic [COUNT_W-1:0] COUNT_NONE  = '1;
    localparam logic [COUNT_W-1:0] COUNT_LOW   = 12'd2;
    localparam logic [COUNT_W-1:0] COUNT_THIN  = 12'd3;
    localparam logic [COUNT_W-1:0] COUNT_GOOD  = 12'd4;
    localparam logic [CONF_W-1:0]  CONF_BASE    = 4'd5;
    localparam logic [CONF_W-1:0]  CONF_ONGOING = 4'd7;

    typedef struct packed {
        logic [COUNT_W-1:0] available_count;
        logic [TIME_W-1:0]  sample_time;
        logic               outage_flag;
        logic               is_last;
    } sample_t;

    typedef struct packed {
        logic [CONF_W-1:0]  confidence_tenths;
        logic [COUNT_W-1:0] least_avail;
        logic [RISK_W-1:0]  risk_class;
        logic [DUR_W-1:0]   window_duration;
        logic [TIME_W-1:0]  window_end;
        logic [TIME_W-1:0]  window_start;
        logic               ongoing;
    } window_t;

    function automatic logic [RISK_W-1:0] classify_risk(
        input logic [COUNT_W-1:0] least,
        input logic [TIME_W-1:0]  dur
    );
        logic [RISK_W-1:0] risk;
        if (least == '0) begin
            risk = RISK_CRITICAL;
        end else if (least <= COUNT_LOW && dur > LONG_LIMIT) begin
            risk = RISK_HIGH;
        end else if (least <= COUNT_THIN && dur > SHORT_LIMIT) begin
            risk = RISK_MEDIUM;
        end else begin
            risk = RISK_LOW;
        end
        return risk;
    endfunction

    // The score stays within 4..9, so no clamping is needed.
    function automatic logic [CONF_W-1:0] score_tenths(
        input logic [COUNT_W-1:0] least,
        input logic [TIME_W-1:0]  dur,
        input logic [RISK_W-1:0]  risk
    );
        logic [CONF_W-1:0] c;
        c = CONF_BASE;
        if (least >= COUNT_GOOD) begin
            c = c + 4'd2;
        end else if (least >= COUNT_LOW) begin
            c = c + 4'd1;
        end
        if (dur <= SHORT_LIMIT) begin
            c = c + 4'd2;
        end else if (dur <= LONG_LIMIT) begin
            c = c + 4'd1;
        end
        if (risk == RISK_CRITICAL) begin
            c = c - 4'd1;
        end
        return c;
    endfunction

endpackage

/* rtl/core/owd_tracker.sv */
// Outage state tracking and window computation for one registered sample.
module owd_tracker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  owd_pkg::sample_t  sample,
    output logic              win_valid,
    output owd_pkg::window_t  win
);

    logic                         window_open_reg, window_open_next;
    logic [owd_pkg::TIME_W-1:0]   open_time_reg, open_time_next;
    logic [owd_pkg::COUNT_W-1:0]  least_count_reg, least_count_next;

    logic [owd_pkg::TIME_W-1:0]   start;
    logic [owd_pkg::COUNT_W-1:0]  least_base;
    logic [owd_pkg::COUNT_W-1:0]  least_new;
    logic [owd_pkg::TIME_W-1:0]   diff;
    logic [owd_pkg::TIME_W-1:0]   dur;
    logic [owd_pkg::RISK_W-1:0]   risk;

    always_comb begin
        start      = window_open_reg ? open_time_reg : sample.sample_time;
        least_base = window_open_reg ? least_count_reg : owd_pkg::COUNT_NONE;
        least_new  = (sample.available_count < least_base) ? sample.available_count
                                                           : least_base;
        diff       = sample.sample_time - start;
        dur        = (sample.sample_time < start) ? '0 : diff;
        risk       = owd_pkg::classify_risk(least_new, dur);

        win.window_start = start;
        win.window_end   = sample.sample_time;
        if (dur[owd_pkg::TIME_W-1:owd_pkg::DUR_W] != '0) begin
            win.window_duration = '1;
        end else begin
            win.window_duration = dur[owd_pkg::DUR_W-1:0];
        end

        if (sample.outage_flag) begin
            win_valid             = sample.is_last;
            win.risk_class        = owd_pkg::RISK_HIGH;
            win.least_avail       = '0;
            win.confidence_tenths = owd_pkg::CONF_ONGOING;
            win.ongoing           = 1'b1;
        end else begin
            win_valid             = window_open_reg;
            win.risk_class        = risk;
            win.least_avail       = least_new;
            win.confidence_tenths = owd_pkg::score_tenths(least_new, dur, risk);
            win.ongoing           = 1'b0;
        end

        window_open_next = window_open_reg;
        open_time_next   = open_time_reg;
        least_count_next = least_count_reg;
        if (take) begin
            if (sample.is_last) begin
                window_open_next = 1'b0;
                open_time_next   = '0;
                least_count_next = owd_pkg::COUNT_NONE;
            end else if (sample.outage_flag) begin
                window_open_next = 1'b1;
                open_time_next   = start;
                least_count_next = least_new;
            end else begin
                window_open_next = 1'b0;
                least_count_next = owd_pkg::COUNT_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_open_reg <= 1'b0;
            open_time_reg   <= '0;
            least_count_reg <= owd_pkg::COUNT_NONE;
        end else begin
            window_open_reg <= window_open_next;
            open_time_reg   <= open_time_next;
            least_count_reg <= least_count_next;
        end
    end

endmodule

/* rtl/core/owd_out_reg.sv */
// Result register that holds one window word for the master side.
module owd_out_reg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  logic                              win_valid,
    input  owd_pkg::window_t                  win,
    output logic                              free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [owd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tuser
);

    logic             valid_reg, valid_next;
    owd_pkg::window_t win_reg, win_next;

    always_comb begin
        free       = !valid_reg || m_tready;
        valid_next = valid_reg && !m_tready;
        win_next   = win_reg;
        if (load) begin
            valid_next = win_valid;
            win_next   = win;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = win_reg.ongoing;
    assign m_tdata  = {7'd0,
                       win_reg.confidence_tenths,
                       win_reg.least_avail,
                       win_reg.risk_class,
                       win_reg.window_duration,
                       win_reg.window_end,
                       win_reg.window_start};

endmodule

/* rtl/core/outage_window_detector.sv */
// Top level of the outage window detector: input register, tracker and result register.
//
//  Channel  Direction  Payload
//  s_       in         tdata: sample_time, available_count; tuser: outage_flag; tlast: is_last
//  m_       out        tdata: window start, end, duration, risk, min count, confidence;
//                      tuser: ongoing
//
// One word is accepted per cycle while m_tready does not stall the result register; each
// sample passes through the input register and the tracker state update into the result register.
// Reset returns the outage state to closed and empties both registers.
// A stall on m_tready holds the result register and backs up into s_tready.
module outage_window_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [owd_pkg::S_TDATA_W-1:0]      s_tdata,  // sample_time, available_count
    input  logic                               s_tuser,  // outage_flag
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [owd_pkg::M_TDATA_W-1:0]      m_tdata,  // start, end, duration, risk,
                                                         // least_avail, confidence
    output logic                               m_tuser   // ongoing
);

    logic              in_valid_reg, in_valid_next;
    owd_pkg::sample_t  in_reg, in_next;
    logic              out_free;
    logic              take;
    logic              win_valid;
    owd_pkg::window_t  win;

    assign take     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next = in_valid_reg && !take;
        in_next       = in_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next           = 1'b1;
            in_next.sample_time     = s_tdata[owd_pkg::TIME_W-1:0];
            in_next.available_count =
                s_tdata[owd_pkg::TIME_W+owd_pkg::COUNT_W-1:owd_pkg::TIME_W];
            in_next.outage_flag     = s_tuser;
            in_next.is_last         = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg <= in_next;
    end

    owd_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .sample    (in_reg),
        .win_valid (win_valid),
        .win       (win)
    );

    owd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take),
        .win_valid (win_valid),
        .win       (win),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
